/* hw/rtl/prq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  // Default sizes
  localparam int NUM_TASKS_DEF  = 64;
  localparam int NUM_LEVELS_DEF = 32;

  // Field widths of one request and one result
  localparam int CMD_W      = 2;
  localparam int TASK_W     = 6;
  localparam int PRIO_W     = 5;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESCHED = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;        // capture the incoming request
    logic              rd_issue;    // read head/tail of the level and the task's link
    logic              ins_write;   // append the task at the tail of its level
    logic              rm_head;     // unlink the task at the head of its level
    logic              walk_start;  // start the predecessor walk at the head
    logic              walk_step;   // follow one link of the walk
    logic              fix;         // relink around the task after the walk hit
    logic              st_set;      // load the status register
    logic [STAT_W-1:0] st_code;
    logic              out_load;    // load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             bad_task;
    logic             bad_level;
    logic             queue_empty;
    logic             level_busy;
    logic             t_is_head;
    logic             walk_nul;
    logic             walk_hit;
    logic             walk_last;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/prq_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module prq_dpath #(
  parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF,
  parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [prq_pkg::CMD_W-1:0]     in_cmd,
  input  wire [prq_pkg::TASK_W-1:0]    in_task,
  input  wire [prq_pkg::PRIO_W-1:0]    in_prio,
  input  wire prq_pkg::dp_cmd_t        ctl,
  output prq_pkg::dp_stat_t            sts,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [prq_pkg::TASK_W-1:0]   out_task,
  output logic [prq_pkg::PRIO_W-1:0]   out_prio,
  output logic [prq_pkg::STAT_W-1:0]   out_stat
);

  localparam int IDX_W  = $clog2(NUM_TASKS);
  localparam int STEP_W = $clog2(NUM_TASKS);
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int TW     = prq_pkg::TASK_W;
  localparam int PW     = prq_pkg::PRIO_W;

  // Request registers
  logic [prq_pkg::CMD_W-1:0]  cmd_q;
  logic [TW-1:0]              t_q;
  logic [PW-1:0]              lvl_q;
  logic [prq_pkg::STAT_W-1:0] status_q;

  // Queue state
  logic [NUM_LEVELS-1:0]      mask_q;
  logic [IDX_W-1:0]           head_mem [NUM_LEVELS];
  logic [IDX_W-1:0]           tail_mem [NUM_LEVELS];
  logic [IDX_W-1:0]           link_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]       link_vld;
  logic [NUM_TASKS-1:0]       link_vld_next;

  // Read data and walk registers
  logic [IDX_W-1:0]           head_q;
  logic [IDX_W-1:0]           tail_q;
  logic [IDX_W-1:0]           link_rd;
  logic                       link_rd_vld;
  logic [IDX_W-1:0]           link_t;
  logic                       link_t_vld;
  logic [IDX_W-1:0]           walk_it;
  logic [STEP_W-1:0]          walk_steps;
  logic [LVL_W-1:0]           top_q;

  // Derived addresses
  logic [IDX_W-1:0]           t_idx;
  logic [LVL_W-1:0]           lvl_idx;
  logic [LVL_W-1:0]           top_idx;
  logic [LVL_W-1:0]           head_addr;
  logic [IDX_W-1:0]           link_addr;
  logic                       busy;
  logic                       peek_ok;

  // Link valid update controls
  logic                       set_en;
  logic [IDX_W-1:0]           set_addr;
  logic                       clr_en;
  logic [IDX_W-1:0]           clr_addr;

  assign t_idx   = IDX_W'(t_q);
  assign lvl_idx = lvl_q[LVL_W-1:0];
  assign busy    = mask_q[lvl_idx];
  assign peek_ok = (cmd_q == prq_pkg::CMD_PEEK) && (status_q == prq_pkg::ST_OK);

  // Find the highest nonempty level
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (mask_q[i]) begin
        top_idx = LVL_W'(i);
      end
    end
  end

  assign head_addr = (cmd_q == prq_pkg::CMD_PEEK) ? top_idx : lvl_idx;

  always_comb begin
    if (ctl.walk_step) begin
      link_addr = link_rd;
    end else if (ctl.walk_start) begin
      link_addr = head_q;
    end else begin
      link_addr = t_idx;
    end
  end

  // Status to the controller
  always_comb begin
    sts.cmd         = cmd_q;
    sts.bad_task    = int'(t_q) >= NUM_TASKS;
    sts.bad_level   = int'(lvl_q) >= NUM_LEVELS;
    sts.queue_empty = (mask_q == '0);
    sts.level_busy  = busy;
    sts.t_is_head   = (head_q == t_idx);
    sts.walk_nul    = !link_rd_vld;
    sts.walk_hit    = (link_rd == t_idx);
    sts.walk_last   = (walk_steps == STEP_W'(NUM_TASKS - 1));
    sts.out_free    = !out_valid || out_ready;
  end

  // Capture the request and track the status
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= in_cmd;
      t_q   <= in_task;
      lvl_q <= in_prio;
    end
    if (ctl.load) begin
      status_q <= prq_pkg::ST_OK;
    end else if (ctl.st_set) begin
      status_q <= ctl.st_code;
    end
  end

  // Registered reads of the level tables and the link memory
  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      head_q <= head_mem[head_addr];
      tail_q <= tail_mem[lvl_idx];
      top_q  <= top_idx;
    end
    if (ctl.rd_issue || ctl.walk_start || ctl.walk_step) begin
      link_rd     <= link_mem[link_addr];
      link_rd_vld <= link_vld[link_addr];
    end
  end

  // Walk registers: keep the removed task's link while walking
  always_ff @(posedge clk) begin
    if (ctl.walk_start) begin
      walk_it    <= head_q;
      walk_steps <= '0;
      link_t     <= link_rd;
      link_t_vld <= link_rd_vld;
    end else if (ctl.walk_step) begin
      walk_it    <= link_rd;
      walk_steps <= walk_steps + STEP_W'(1);
    end
  end

  // Level table writes
  always_ff @(posedge clk) begin
    if (ctl.ins_write && !busy) begin
      head_mem[lvl_idx] <= t_idx;
    end else if (ctl.rm_head && link_rd_vld) begin
      head_mem[lvl_idx] <= link_rd;
    end
    if (ctl.ins_write) begin
      tail_mem[lvl_idx] <= t_idx;
    end else if (ctl.fix && !link_t_vld) begin
      tail_mem[lvl_idx] <= walk_it;
    end
  end

  // Link memory writes
  always_ff @(posedge clk) begin
    if (ctl.ins_write && busy) begin
      link_mem[tail_q] <= t_idx;
    end else if (ctl.fix && link_t_vld) begin
      link_mem[walk_it] <= link_t;
    end
  end

  // Link valid bits: an invalid entry reads as null; a clear wins over a set
  assign set_en   = (ctl.ins_write && busy) || (ctl.fix && link_t_vld);
  assign set_addr = ctl.ins_write ? tail_q : walk_it;
  assign clr_en   = ctl.ins_write || (ctl.rm_head && link_rd_vld) || ctl.fix;
  assign clr_addr = (ctl.fix && !link_t_vld) ? walk_it : t_idx;

  always_comb begin
    link_vld_next = link_vld;
    if (set_en) begin
      link_vld_next[set_addr] = 1'b1;
    end
    if (clr_en) begin
      link_vld_next[clr_addr] = 1'b0;
    end
  end

  // Nonempty mask and link valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_q   <= '0;
      link_vld <= '0;
    end else begin
      link_vld <= link_vld_next;
      if (ctl.ins_write) begin
        mask_q[lvl_idx] <= 1'b1;
      end else if (ctl.rm_head && !link_rd_vld) begin
        mask_q[lvl_idx] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_task <= peek_ok ? TW'(head_q) : '0;
      out_prio <= peek_ok ? PW'(top_q) : '0;
      out_stat <= status_q;
    end
  end

  // Result is never loaded over one that is still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // An insert leaves its level nonempty
  a_ins_mask: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_write |=> mask_q[$past(lvl_idx)])
    else $error("level empty after insert");

  // The walk never goes past its bound
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.walk_step |-> (walk_steps != STEP_W'(NUM_TASKS - 1)))
    else $error("walk ran past its bound");

  // A successful peek reports a nonempty level
  a_peek_level: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && peek_ok) |-> mask_q[top_q])
    else $error("peek reported an empty level");

endmodule

`default_nettype wire

/* hw/rtl/prq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module prq_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire prq_pkg::dp_stat_t   sts,
  output prq_pkg::dp_cmd_t         ctl
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_ISSUE      = 3'd1;
  localparam logic [2:0] S_EXEC       = 3'd2;
  localparam logic [2:0] S_WALK       = 3'd3;
  localparam logic [2:0] S_FIX        = 3'd4;
  localparam logic [2:0] S_REINS      = 3'd5;
  localparam logic [2:0] S_REINS_EXEC = 3'd6;
  localparam logic [2:0] S_DONE       = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] after_remove;

  assign in_ready     = (state == S_IDLE);
  assign after_remove = (sts.cmd == prq_pkg::CMD_RESCHED) ? S_REINS : S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one request
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts.cmd == prq_pkg::CMD_PEEK) begin
          if (sts.queue_empty) begin
            ctl.st_set  = 1'b1;
            ctl.st_code = prq_pkg::ST_EMPTY;
            state_next  = S_DONE;
          end else begin
            ctl.rd_issue = 1'b1;
            state_next   = S_EXEC;
          end
        end else if (sts.bad_task) begin
          ctl.st_set  = 1'b1;
          ctl.st_code = prq_pkg::ST_MISSING;
          state_next  = S_DONE;
        end else if (sts.bad_level) begin
          ctl.st_set  = 1'b1;
          ctl.st_code = prq_pkg::ST_EMPTY;
          state_next  = S_DONE;
        end else begin
          ctl.rd_issue = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.cmd)
          prq_pkg::CMD_PEEK: begin
            state_next = S_DONE;
          end
          prq_pkg::CMD_INSERT: begin
            ctl.ins_write = 1'b1;
            state_next    = S_DONE;
          end
          default: begin
            if (!sts.level_busy) begin
              ctl.st_set  = 1'b1;
              ctl.st_code = prq_pkg::ST_EMPTY;
              state_next  = after_remove;
            end else if (sts.t_is_head) begin
              ctl.rm_head = 1'b1;
              state_next  = after_remove;
            end else begin
              ctl.walk_start = 1'b1;
              state_next     = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        if (sts.walk_nul) begin
          ctl.st_set  = 1'b1;
          ctl.st_code = prq_pkg::ST_MISSING;
          state_next  = after_remove;
        end else if (sts.walk_hit) begin
          state_next = S_FIX;
        end else if (sts.walk_last) begin
          ctl.st_set  = 1'b1;
          ctl.st_code = prq_pkg::ST_MISSING;
          state_next  = after_remove;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_FIX: begin
        ctl.fix    = 1'b1;
        state_next = after_remove;
      end
      S_REINS: begin
        ctl.rd_issue = 1'b1;
        state_next   = S_REINS_EXEC;
      end
      S_REINS_EXEC: begin
        ctl.ins_write = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/priority_ready_queue_unit.sv */
// A peek of an empty queue or a request with an id or level out of range is answered
// without a table read; other peeks, inserts and removes of a level head or from an empty
// level read the level tables once; a remove that walks the level makes at most NUM_TASKS
// link reads, plus a relink on a hit; reschedule adds a reread and an insert.
// One request at a time: the next is taken the cycle after the result is registered.
// Reset clears the mask and link valid bits at once.
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue_unit #(
  parameter int NUM_TASKS  = prq_pkg::NUM_TASKS_DEF,
  parameter int NUM_LEVELS = prq_pkg::NUM_LEVELS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // cmd [1:0], task_id [7:2], level [12:8], zero [15:13]
  input  wire  [prq_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // head_task [5:0], head_priority [10:6], status [12:11], zero [15:13]
  output logic [prq_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int CW = prq_pkg::CMD_W;
  localparam int TW = prq_pkg::TASK_W;
  localparam int PW = prq_pkg::PRIO_W;
  localparam int SW = prq_pkg::STAT_W;

  prq_pkg::dp_cmd_t   ctl;
  prq_pkg::dp_stat_t  sts;
  logic [TW-1:0]      out_task;
  logic [PW-1:0]      out_prio;
  logic [SW-1:0]      out_stat;

  // Sequencer
  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Queue storage and result register
  prq_dpath #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (s_tdata[CW-1:0]),
    .in_task   (s_tdata[CW+TW-1:CW]),
    .in_prio   (s_tdata[CW+TW+PW-1:CW+TW]),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_task  (out_task),
    .out_prio  (out_prio),
    .out_stat  (out_stat)
  );

  // Pack the result
  assign m_tdata = {{(prq_pkg::OUT_DATA_W - TW - PW - SW){1'b0}}, out_stat, out_prio, out_task};

endmodule

`default_nettype wire
